FILE: rtl/core/segment_length_and_angle_core_assert.svh
// Assertion macros used by the checker file of the segment length and angle core.
`ifndef SEGMENT_LENGTH_AND_ANGLE_CORE_ASSERT_SVH
`define SEGMENT_LENGTH_AND_ANGLE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SLA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sla_pkg.sv
// Package with widths, data types and boundary tables of the segment length and angle core.
`default_nettype none

package sla_pkg;

  // Field and datapath widths.
  localparam int COORD_BITS       = 15;
  localparam int LENGTH_FRAC_BITS = 8;
  localparam int DIFF_W           = COORD_BITS + 1;
  localparam int ABS_W            = COORD_BITS;
  localparam int SQR_W            = 2 * ABS_W;
  localparam int SQ_W             = SQR_W + 1;
  localparam int ROOT_W           = (SQ_W + 2 * LENGTH_FRAC_BITS + 1) / 2;
  localparam int T_W              = 2 * ROOT_W;
  localparam int REM_W            = ROOT_W + 1;
  localparam int LEN_W            = 24;
  localparam int DEG_W            = 9;
  localparam int ALPHA_W          = 7;

  // Angle search: half-degree boundaries of the first octant.
  localparam int BOUNDARIES = 45;
  localparam int CNT_W      = $clog2(BOUNDARIES + 1);
  localparam int TAB_W      = 47;
  localparam int Q_SHIFT    = 60 - TAB_W;
  localparam int PROD_W     = ABS_W + TAB_W;
  localparam int ANGLE_STAGES = 3;
  localparam int ANGLE_PAD  = ROOT_W - ANGLE_STAGES * CNT_W;

  localparam logic [LEN_W-1:0] LEN_MAX     = '1;
  localparam logic [CNT_W-1:0] PROBE_INIT  = {1'b1, {(CNT_W - 1){1'b0}}};
  localparam int               RIGHT_ANGLE = 90;
  localparam int               HALF_TURN   = 180;
  localparam int               FULL_TURN   = 360;

  // Series lengths used when the tables are built.
  localparam int ATAN_TERMS   = 32;
  localparam int TAYLOR_TERMS = 16;
  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;

  typedef logic [BOUNDARIES-1:0][TAB_W-1:0] bnd_table_t;

  // Direction flags of one segment after folding into the first octant.
  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic swap;
    logic zero;
  } dir_flags_t;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [T_W-1:0]    t;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_data_t;

  // State handed from one angle search cell to the next.
  typedef struct packed {
    logic [ABS_W-1:0] a;
    logic [ABS_W-1:0] b;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] probe;
    dir_flags_t       flags;
  } angle_data_t;

  // Product of two Q60 values, kept in Q60.
  function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[123:60];
  endfunction

  // Sine or cosine of each half-degree boundary in Q47, worked out at elaboration.
  function automatic bnd_table_t build_bnd(input logic want_sin);
    logic [63:0] p, pos, neg, atan5, atan239, pi_q60, half_deg;
    logic [63:0] x, ct, st, cp, cn, sp, sn, res;
    bnd_table_t tab;
    tab = '0;
    // atan(1/5)
    p = Q60_ONE / 64'd5;
    pos = '0;
    neg = '0;
    for (int k = 0; k < ATAN_TERMS; k++) begin
      if (p != 64'd0) begin
        if (k % 2 == 0) pos = pos + p / 64'(2 * k + 1);
        else neg = neg + p / 64'(2 * k + 1);
        p = p / 64'd25;
      end
    end
    atan5 = pos - neg;
    // atan(1/239)
    p = Q60_ONE / 64'd239;
    pos = '0;
    neg = '0;
    for (int k = 0; k < ATAN_TERMS; k++) begin
      if (p != 64'd0) begin
        if (k % 2 == 0) pos = pos + p / 64'(2 * k + 1);
        else neg = neg + p / 64'(2 * k + 1);
        p = p / 64'd57121;
      end
    end
    atan239 = pos - neg;
    pi_q60 = 64'd4 * (64'd4 * atan5 - atan239);
    half_deg = pi_q60 / 64'd360;
    // Taylor series for each boundary angle.
    for (int h = 0; h < BOUNDARIES; h++) begin
      x = half_deg * 64'(2 * h + 1);
      ct = Q60_ONE;
      st = x;
      cp = '0;
      cn = '0;
      sp = '0;
      sn = '0;
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
        if (k % 2 == 0) begin
          cp = cp + ct;
          sp = sp + st;
        end else begin
          cn = cn + ct;
          sn = sn + st;
        end
        ct = mul_q60(mul_q60(ct, x), x) / 64'((2 * k + 1) * (2 * k + 2));
        st = mul_q60(mul_q60(st, x), x) / 64'((2 * k + 2) * (2 * k + 3));
      end
      res = want_sin ? ((sp - sn) >> Q_SHIFT) : ((cp - cn) >> Q_SHIFT);
      tab[h] = res[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam bnd_table_t BND_COS = build_bnd(1'b0);
  localparam bnd_table_t BND_SIN = build_bnd(1'b1);

endpackage

`default_nettype wire

FILE: rtl/core/sla_if.sv
// Handshake interfaces for the segment items and the result items.
`default_nettype none

// Segment channel: two endpoints per item.
interface sla_seg_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sla_pkg::COORD_BITS-1:0] start_x;
  logic signed [sla_pkg::COORD_BITS-1:0] start_y;
  logic signed [sla_pkg::COORD_BITS-1:0] end_x;
  logic signed [sla_pkg::COORD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

// Result channel: length and direction per item.
interface sla_res_if;
  logic                           valid;
  logic                           ready;
  logic [sla_pkg::LEN_W-1:0]      length_q8;
  logic [sla_pkg::DEG_W-1:0]      angle_degrees;

  modport source (output valid, output length_q8, output angle_degrees, input ready);
  modport sink (input valid, input length_q8, input angle_degrees, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/segment_length_and_angle_core.sv
// Top level of the segment length and angle core.
//
// Channel  Dir  Payload
// segment  in   start_x, start_y, end_x, end_y: 15-bit signed
// result   out  length_q8: 24-bit unsigned Q8; angle_degrees: 9-bit unsigned, 0..360
//
// One item is taken every clock while the chain is not held; each result passes
// through four front stages, 24 square root cells (one root bit each)
// and the output register; the six angle search cells of three stages each
// run beside the root cells and are padded to the same depth.
// Reset (rst, synchronous) clears all valid bits. While a result waits
// unaccepted the whole chain holds and segment.ready is low.
`default_nettype none

module segment_length_and_angle_core (
  input  logic       clk,
  input  logic       rst,
  sla_seg_if.sink    segment,
  sla_res_if.source  result
);

  logic adv;
  logic res_valid;

  logic                 sqrt_valid [sla_pkg::ROOT_W+1];
  sla_pkg::sqrt_data_t  sqrt_data  [sla_pkg::ROOT_W+1];
  sla_pkg::angle_data_t angle_data [sla_pkg::CNT_W+1];
  sla_pkg::angle_data_t pad        [sla_pkg::ANGLE_PAD];

  sla_pkg::sqrt_data_t       fin;
  sla_pkg::angle_data_t      ang;
  logic                      round_up;
  logic [sla_pkg::ROOT_W:0]  len_wide;
  logic [sla_pkg::LEN_W-1:0] len_next, length_q8;
  logic [sla_pkg::ALPHA_W-1:0] alpha;
  logic [sla_pkg::DEG_W-1:0] deg_next, angle_degrees;

  // The chain moves whenever the output register is free or being emptied.
  assign adv           = !res_valid || result.ready;
  assign segment.ready = adv;

  sla_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .segment    (segment),
    .valid      (sqrt_valid[0]),
    .sqrt_init  (sqrt_data[0]),
    .angle_init (angle_data[0])
  );

  // Square root chain.
  for (genvar i = 0; i < sla_pkg::ROOT_W; i++) begin : g_sqrt
    sla_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .src_valid (sqrt_valid[i]),
      .src       (sqrt_data[i]),
      .valid     (sqrt_valid[i+1]),
      .data      (sqrt_data[i+1])
    );
  end

  // Angle search chain.
  for (genvar i = 0; i < sla_pkg::CNT_W; i++) begin : g_angle
    sla_angle_cell u_cell (
      .clk  (clk),
      .adv  (adv),
      .src  (angle_data[i]),
      .data (angle_data[i+1])
    );
  end

  // Delay line that lines the angle search up with the root chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      pad[0] <= angle_data[sla_pkg::CNT_W];
      for (int i = 1; i < sla_pkg::ANGLE_PAD; i++) begin
        pad[i] <= pad[i-1];
      end
    end
  end

  // Length rounding: round up when the remainder exceeds the root.
  always_comb begin
    fin      = sqrt_data[sla_pkg::ROOT_W];
    round_up = fin.rem > sla_pkg::REM_W'(fin.root);
    len_wide = (sla_pkg::ROOT_W + 1)'(fin.root) + (sla_pkg::ROOT_W + 1)'(round_up);
    len_next = (len_wide > (sla_pkg::ROOT_W + 1)'(sla_pkg::LEN_MAX)) ? sla_pkg::LEN_MAX
             : len_wide[sla_pkg::LEN_W-1:0];
  end

  // Unfold the octant count into a full-turn direction.
  always_comb begin
    ang   = pad[sla_pkg::ANGLE_PAD-1];
    alpha = ang.flags.swap
          ? sla_pkg::ALPHA_W'(sla_pkg::RIGHT_ANGLE) - sla_pkg::ALPHA_W'(ang.cnt)
          : sla_pkg::ALPHA_W'(ang.cnt);
    if (ang.flags.zero) begin
      deg_next = '0;
    end else if (!ang.flags.dy_neg) begin
      deg_next = ang.flags.dx_neg
               ? sla_pkg::DEG_W'(sla_pkg::HALF_TURN) - sla_pkg::DEG_W'(alpha)
               : sla_pkg::DEG_W'(alpha);
    end else begin
      deg_next = ang.flags.dx_neg
               ? sla_pkg::DEG_W'(sla_pkg::HALF_TURN) + sla_pkg::DEG_W'(alpha)
               : sla_pkg::DEG_W'(sla_pkg::FULL_TURN) - sla_pkg::DEG_W'(alpha);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= sqrt_valid[sla_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      length_q8     <= len_next;
      angle_degrees <= deg_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.length_q8     = length_q8;
  assign result.angle_degrees = angle_degrees;

endmodule

`default_nettype wire

FILE: rtl/core/sla_front.sv
// Front stages: differences, magnitudes, octant fold and sum of squares.
`default_nettype none

module sla_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  sla_seg_if.sink             segment,
  output logic                valid,
  output sla_pkg::sqrt_data_t sqrt_init,
  output sla_pkg::angle_data_t angle_init
);

  logic a_valid, b_valid, c_valid;

  // Stage A: coordinate differences.
  logic [sla_pkg::DIFF_W-1:0] dx, dy, dx_next, dy_next;

  // Stage B: magnitudes, folded pair and flags.
  logic [sla_pkg::ABS_W-1:0] u, v, u_next, v_next;
  logic [sla_pkg::ABS_W-1:0] b_a, b_b, b_a_next, b_b_next;
  logic [sla_pkg::DIFF_W-1:0] dx_neg_val, dy_neg_val;
  sla_pkg::dir_flags_t b_flags, b_flags_next;

  // Stage C: squares.
  logic [sla_pkg::SQR_W-1:0] usq, vsq;
  logic [sla_pkg::ABS_W-1:0] c_a, c_b;
  sla_pkg::dir_flags_t c_flags;

  logic [sla_pkg::SQ_W-1:0] sq_sum;

  // Valid bits move with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      valid   <= 1'b0;
    end else if (adv) begin
      a_valid <= segment.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      valid   <= c_valid;
    end
  end

  // Sign-extended differences, end minus start.
  always_comb begin
    dx_next = {segment.end_x[sla_pkg::COORD_BITS-1], segment.end_x}
            - {segment.start_x[sla_pkg::COORD_BITS-1], segment.start_x};
    dy_next = {segment.end_y[sla_pkg::COORD_BITS-1], segment.end_y}
            - {segment.start_y[sla_pkg::COORD_BITS-1], segment.start_y};
  end

  // Magnitudes and the fold into the first octant.
  always_comb begin
    dx_neg_val = ~dx + 1'b1;
    dy_neg_val = ~dy + 1'b1;
    u_next = dx[sla_pkg::DIFF_W-1] ? dx_neg_val[sla_pkg::ABS_W-1:0] : dx[sla_pkg::ABS_W-1:0];
    v_next = dy[sla_pkg::DIFF_W-1] ? dy_neg_val[sla_pkg::ABS_W-1:0] : dy[sla_pkg::ABS_W-1:0];
    b_flags_next.dx_neg = dx[sla_pkg::DIFF_W-1];
    b_flags_next.dy_neg = dy[sla_pkg::DIFF_W-1];
    b_flags_next.swap   = v_next > u_next;
    b_flags_next.zero   = (u_next == '0) && (v_next == '0);
    b_a_next = b_flags_next.swap ? v_next : u_next;
    b_b_next = b_flags_next.swap ? u_next : v_next;
  end

  assign sq_sum = sla_pkg::SQ_W'(usq) + sla_pkg::SQ_W'(vsq);

  // Payload registers of the four stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      dx      <= dx_next;
      dy      <= dy_next;
      u       <= u_next;
      v       <= v_next;
      b_a     <= b_a_next;
      b_b     <= b_b_next;
      b_flags <= b_flags_next;
      usq     <= sla_pkg::SQR_W'(u) * sla_pkg::SQR_W'(u);
      vsq     <= sla_pkg::SQR_W'(v) * sla_pkg::SQR_W'(v);
      c_a     <= b_a;
      c_b     <= b_b;
      c_flags <= b_flags;
      sqrt_init.t        <= sla_pkg::T_W'(sq_sum) << (2 * sla_pkg::LENGTH_FRAC_BITS);
      sqrt_init.rem      <= '0;
      sqrt_init.root     <= '0;
      angle_init.a       <= c_a;
      angle_init.b       <= c_b;
      angle_init.cnt     <= '0;
      angle_init.probe   <= sla_pkg::PROBE_INIT;
      angle_init.flags   <= c_flags;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sla_sqrt_cell.sv
// One digit of the square root: takes two radicand bits, yields one root bit.
`default_nettype none

module sla_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                src_valid,
  input  sla_pkg::sqrt_data_t src,
  output logic                valid,
  output sla_pkg::sqrt_data_t data
);

  logic [sla_pkg::REM_W+1:0] rem_sh, trial, diff;
  logic                      take;
  sla_pkg::sqrt_data_t       data_next;

  // Restoring step: bring down two bits, try to subtract 4r+1.
  always_comb begin
    rem_sh = {src.rem, src.t[sla_pkg::T_W-1 -: 2]};
    trial  = {1'b0, src.root, 2'b01};
    take   = rem_sh >= trial;
    diff   = rem_sh - trial;
    data_next.t    = {src.t[sla_pkg::T_W-3:0], 2'b00};
    data_next.rem  = take ? diff[sla_pkg::REM_W-1:0] : rem_sh[sla_pkg::REM_W-1:0];
    data_next.root = {src.root[sla_pkg::ROOT_W-2:0], take};
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= src_valid;
    end
  end

  // Cell state.
  always_ff @(posedge clk) begin
    if (adv) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sla_angle_cell.sv
// One bit of the boundary count search: table read, cross products, compare.
`default_nettype none

module sla_angle_cell (
  input  logic                 clk,
  input  logic                 adv,
  input  sla_pkg::angle_data_t src,
  output sla_pkg::angle_data_t data
);

  logic [sla_pkg::CNT_W-1:0] trial, idx;
  logic                      in_range;

  // First stage: boundary sine and cosine.
  sla_pkg::angle_data_t      s1;
  logic [sla_pkg::CNT_W-1:0] s1_trial;
  logic                      s1_ok;
  logic [sla_pkg::TAB_W-1:0] s1_cos, s1_sin;

  // Second stage: cross products.
  sla_pkg::angle_data_t       s2;
  logic [sla_pkg::CNT_W-1:0]  s2_trial;
  logic                       s2_ok;
  logic [sla_pkg::PROD_W-1:0] s2_prod_b, s2_prod_a;

  logic                 hit;
  sla_pkg::angle_data_t data_next;

  // The trial count adds this cell's probe bit; it tests boundary trial-1.
  always_comb begin
    trial    = src.cnt | src.probe;
    in_range = trial <= sla_pkg::CNT_W'(sla_pkg::BOUNDARIES);
    idx      = in_range ? trial - 1'b1 : '0;
  end

  // The vector lies beyond the boundary when b*cos exceeds a*sin.
  always_comb begin
    hit = s2_ok && (s2_prod_b > s2_prod_a);
    data_next       = s2;
    data_next.cnt   = hit ? s2_trial : s2.cnt;
    data_next.probe = s2.probe >> 1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1        <= src;
      s1_trial  <= trial;
      s1_ok     <= in_range;
      s1_cos    <= sla_pkg::BND_COS[idx];
      s1_sin    <= sla_pkg::BND_SIN[idx];
      s2        <= s1;
      s2_trial  <= s1_trial;
      s2_ok     <= s1_ok;
      s2_prod_b <= sla_pkg::PROD_W'(s1.b) * sla_pkg::PROD_W'(s1_cos);
      s2_prod_a <= sla_pkg::PROD_W'(s1.a) * sla_pkg::PROD_W'(s1_sin);
      data      <= data_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sla_checker.sv
// Port-level checks of the segment length and angle core, bound to the top level.
`default_nettype none

`include "segment_length_and_angle_core_assert.svh"

module sla_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      seg_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [sla_pkg::LEN_W-1:0] length_q8,
  input logic [sla_pkg::DEG_W-1:0] angle_degrees
);

  // A result that waits keeps its value.
  `SLA_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(length_q8) && $stable(angle_degrees), "result item changed while stalled")

  // The direction never goes past a full turn.
  `SLA_ASSERT_NOW(a_angle_range, clk, rst, res_valid, angle_degrees <= sla_pkg::DEG_W'(sla_pkg::FULL_TURN), "angle above full turn")

  // A zero-length segment points at zero degrees.
  `SLA_ASSERT_NOW(a_zero_angle, clk, rst, res_valid && (length_q8 == '0), angle_degrees == '0, "zero length with nonzero angle")

  // With the output register empty a new item is always taken.
  `SLA_ASSERT_NOW(a_ready_free, clk, rst, !res_valid, seg_ready, "segment stalled with empty output")

  // Nothing comes out straight after reset.
  `SLA_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !res_valid, "result valid after reset")

endmodule

bind segment_length_and_angle_core sla_checker u_sla_checker (
  .clk           (clk),
  .rst           (rst),
  .seg_ready     (segment.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .length_q8     (result.length_q8),
  .angle_degrees (result.angle_degrees)
);

`default_nettype wire
